/* rtl/core/pc_keyboard_scancode_link_macros.svh */
// Assertion macros shared by the checker of the keyboard scancode link.
`ifndef PC_KEYBOARD_SCANCODE_LINK_MACROS_SVH
`define PC_KEYBOARD_SCANCODE_LINK_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PCKB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PCKB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pckb_pkg.sv */
// Shared widths, command codes and fixed codes of the keyboard scancode link.
package pckb_pkg;

    localparam int CMD_W   = 2;
    localparam int CODE_W  = 8;
    localparam int LEFT_W  = 5;
    localparam int TIMER_W = 8;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_CTRL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KEY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // Fixed codes and values.
    localparam logic [TIMER_W-1:0] TIMER_FIRED     = 8'hFF;
    localparam logic [CODE_W-1:0]  SELF_TEST_CODE  = 8'hAA;
    localparam logic [TIMER_W-1:0] THRESHOLD_RESET = 8'd20;

endpackage

/* rtl/core/pckb_if.sv */
// Valid/ready channel interfaces for input items and sent scancodes.
interface pckb_in_if
    import pckb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic              enable_clear_line;
    logic              clock_low_line;
    logic [CODE_W-1:0] key_code;

    modport source (output valid, command, enable_clear_line, clock_low_line, key_code,
                    input ready);
    modport sink   (input valid, command, enable_clear_line, clock_low_line, key_code,
                    output ready);
endinterface

interface pckb_out_if
    import pckb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] scancode_out;
    logic [LEFT_W-1:0] codes_left;

    modport source (output valid, scancode_out, codes_left, input ready);
    modport sink   (input valid, scancode_out, codes_left, output ready);
endinterface

/* rtl/core/pckb_code_queue.sv */
// Scancode storage with one write port and a registered head read with bypass.
module pckb_code_queue
    import pckb_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CODE_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [CODE_W-1:0] rd_data
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_mem_reg;
    logic [CODE_W-1:0] byp_data_reg;
    logic              byp_reg;

    // Storage write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read of the entry that will be at the head next cycle.
    always_ff @(posedge clk)
    begin
        rd_mem_reg   <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // A write to the same entry in the same cycle wins over the old contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_mem_reg;

endmodule

/* rtl/core/pc_keyboard_scancode_link.sv */
// Top level of the keyboard side of the XT keyboard link.
//
//  Channel   Direction  Payload
//  items     in         command, enable_clear_line, clock_low_line, key_code
//  results   out        scancode_out, codes_left
//  cfg       in         cfg_wr_data (reset_threshold_ms), written when cfg_wr_en is high
//
// An item is taken into an input register, processed from it when the result register
// can advance, and any sent scancode lands in the result register; one item is accepted
// per cycle unless it stalls. Sent scancodes are offered from the result register.
// The head scancode is read from storage at the next head address, with a write bypass.
// Reset sets enable-clear low and the clock level to 1, and clears the timer,
// the queue pointers and both stage valids; the threshold returns to 20.
// A stalled result register holds the input stage; items are refused only then.
module pc_keyboard_scancode_link
    import pckb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    pckb_in_if.sink             items,
    pckb_out_if.source          results,
    input  logic                cfg_wr_en,
    input  logic [TIMER_W-1:0]  cfg_wr_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    // Configuration register.
    logic [TIMER_W-1:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // Input register stage.
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic              s1_ec_reg;
    logic              s1_cl_reg;
    logic [CODE_W-1:0] s1_key_reg;
    logic              advance;
    logic              in_xfer;

    assign advance     = !results.valid || results.ready;
    assign items.ready = !s1_valid_reg || advance;
    assign in_xfer     = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg <= items.command;
            s1_ec_reg  <= items.enable_clear_line;
            s1_cl_reg  <= items.clock_low_line;
            s1_key_reg <= items.key_code;
        end
    end

    // Link state.
    logic               ec_reg, ec_next;
    logic               cl_reg, cl_next;
    logic               ack_reg, ack_next;
    logic [TIMER_W-1:0] low_reg, low_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;

    // Queue storage signals.
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CODE_W-1:0] wr_data;
    logic [CODE_W-1:0] head_code;

    // Result stage signals.
    logic              res_valid;
    logic [CODE_W-1:0] res_code;
    logic [LEFT_W-1:0] res_left;
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [LEFT_W-1:0] out_left_reg;

    logic               proc;
    logic [SW-1:0]      tail_sum;
    logic [SW-1:0]      tail_wrap;
    logic [AW-1:0]      head_inc;
    logic [TIMER_W-1:0] low_inc;

    assign proc = s1_valid_reg && advance;

    // Tail slot and head step, each with a single wrap correction.
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap = (tail_sum >= SW'(QUEUE_DEPTH)) ? tail_sum - SW'(QUEUE_DEPTH) : tail_sum;
    assign head_inc  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign low_inc   = low_reg + 1'b1;

    // Per-item state update and send decision.
    always_comb
    begin
        ec_next    = ec_reg;
        cl_next    = cl_reg;
        ack_next   = ack_reg;
        low_next   = low_reg;
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(tail_wrap);
        wr_data    = s1_key_reg;
        res_valid  = 1'b0;
        res_code   = head_code;
        res_left   = LEFT_W'(count_reg - 1'b1);
        if (proc)
        begin
            case (s1_cmd_reg)
                CMD_CTRL:
                begin
                    ec_next = s1_ec_reg;
                    cl_next = s1_cl_reg;
                    // Falling enable/clear with the clock released acknowledges a send.
                    if (ec_reg && !s1_ec_reg && s1_cl_reg)
                    begin
                        ack_next = 1'b0;
                    end
                    // Falling clock line restarts the low-time count.
                    if (cl_reg && !s1_cl_reg)
                    begin
                        low_next = '0;
                    end
                end
                CMD_KEY:
                begin
                    if (count_reg < CW'(QUEUE_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    if (!cl_reg)
                    begin
                        if (low_reg != TIMER_FIRED)
                        begin
                            if (low_inc < threshold_reg)
                            begin
                                low_next = low_inc;
                            end
                            else
                            begin
                                // Keyboard reset: empty the queue and queue the self-test code.
                                low_next   = TIMER_FIRED;
                                ack_next   = 1'b0;
                                head_next  = '0;
                                count_next = CW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = SELF_TEST_CODE;
                            end
                        end
                    end
                    else if (!ec_reg && !ack_reg && (count_reg != '0))
                    begin
                        res_valid  = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                        ack_next   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_reg    <= 1'b0;
            cl_reg    <= 1'b1;
            ack_reg   <= 1'b0;
            low_reg   <= '0;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            ec_reg    <= ec_next;
            cl_reg    <= cl_next;
            ack_reg   <= ack_next;
            low_reg   <= low_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Scancode storage.
    pckb_code_queue #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (head_code)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_code_reg <= res_code;
            out_left_reg <= res_left;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.scancode_out = out_code_reg;
    assign results.codes_left   = out_left_reg;

endmodule

/* rtl/core/pckb_checker.sv */
// Port-level checks of the keyboard scancode link and their bind.
`include "pc_keyboard_scancode_link_macros.svh"

module pckb_checker
    import pckb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [LEFT_W-1:0] out_left
);

    // A result waiting for transfer stays offered.
    `PCKB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // With no result pending the input side never stalls.
    `PCKB_ASSERT_NOW(a_in_free, !out_valid, in_ready, "items refused with empty result register")

    // After a send fewer than a full queue of codes remain.
    `PCKB_ASSERT_NOW(a_left_bound, out_valid && (QUEUE_DEPTH < 32),
        out_left < LEFT_W'(QUEUE_DEPTH), "codes_left exceeds queue depth")

    // A stalled input with a pending result means the result side is blocked.
    `PCKB_ASSERT_NOW(a_stall_cause, in_valid && !in_ready, out_valid && !out_ready,
        "items refused without a blocked result")

endmodule

bind pc_keyboard_scancode_link pckb_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pckb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_left  (results.codes_left)
);
